>>> hw/rtl/xcfr_pkg.sv
// ----------------------------------------------------------------------------
// xcfr_pkg
// Shared types, codes and reset values of the XOR-checked frame receiver.
// ----------------------------------------------------------------------------
package xcfr_pkg;

  // Framing bytes
  localparam logic [7:0] StartByte = 8'h02;
  localparam logic [7:0] EndByte   = 8'h03;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] RegExpCmd    = 3'd0;
  localparam logic [CfgIdxW-1:0] RegHuntLimit = 3'd1;
  localparam logic [CfgIdxW-1:0] RegHdrTo     = 3'd2;
  localparam logic [CfgIdxW-1:0] RegDataTo    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegFootTo    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegLenMsb    = 3'd5;
  localparam int unsigned CfgDataW = 16;

  // Configuration reset values
  localparam logic [7:0]  ExpCmdRst    = 8'd0;
  localparam logic [15:0] HuntLimitRst = 16'd2000;
  localparam logic [15:0] HdrToRst     = 16'd100;
  localparam logic [15:0] DataToRst    = 16'd500;
  localparam logic [15:0] FootToRst    = 16'd100;
  localparam logic        LenMsbRst    = 1'b1;

  // Input item kinds (func)
  localparam logic [1:0] FuncByte  = 2'd0;
  localparam logic [1:0] FuncTick  = 2'd1;
  localparam logic [1:0] FuncStart = 2'd2;

  // Result kinds (out_kind)
  localparam logic [1:0] KindNone    = 2'd0;
  localparam logic [1:0] KindPayload = 2'd1;
  localparam logic [1:0] KindDone    = 2'd2;

  // Frame status codes
  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StHdrTo   = 3'd1;
  localparam logic [2:0] StDataTo  = 3'd2;
  localparam logic [2:0] StFootTo  = 3'd3;
  localparam logic [2:0] StBad     = 3'd4;
  localparam logic [2:0] StNoStart = 3'd5;

  typedef enum logic [7:0] {
    PhIdle  = 8'b0000_0001,
    PhHunt  = 8'b0000_0010,
    PhCmd   = 8'b0000_0100,
    PhLen1  = 8'b0000_1000,
    PhLen2  = 8'b0001_0000,
    PhData  = 8'b0010_0000,
    PhCheck = 8'b0100_0000,
    PhEnd   = 8'b1000_0000
  } phase_e;

  typedef struct packed {
    logic [7:0]  exp_cmd;
    logic [15:0] hunt_limit;
    logic [15:0] hdr_to;
    logic [15:0] data_to;
    logic [15:0] foot_to;
    logic        len_msb;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  command;
    logic [15:0] length;
    logic [2:0]  status;
    logic [7:0]  payload;
    logic [1:0]  kind;
  } result_t;

  localparam int unsigned OutDataW = 40;

endpackage

>>> hw/rtl/xcfr_cfg_regs.sv
// ----------------------------------------------------------------------------
// xcfr_cfg_regs
// Configuration register bank, written through a plain write port.
// ----------------------------------------------------------------------------
module xcfr_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          we_i,
  input  logic [xcfr_pkg::CfgIdxW-1:0]  idx_i,
  input  logic [xcfr_pkg::CfgDataW-1:0] data_i,
  output xcfr_pkg::cfg_t                cfg_o
);
  import xcfr_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (idx_i)
        RegExpCmd:    cfg_d.exp_cmd    = data_i[7:0];
        RegHuntLimit: cfg_d.hunt_limit = data_i;
        RegHdrTo:     cfg_d.hdr_to     = data_i;
        RegDataTo:    cfg_d.data_to    = data_i;
        RegFootTo:    cfg_d.foot_to    = data_i;
        RegLenMsb:    cfg_d.len_msb    = data_i[0];
        default:      ;  // unmapped index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.exp_cmd    <= ExpCmdRst;
      cfg_q.hunt_limit <= HuntLimitRst;
      cfg_q.hdr_to     <= HdrToRst;
      cfg_q.data_to    <= DataToRst;
      cfg_q.foot_to    <= FootToRst;
      cfg_q.len_msb    <= LenMsbRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hw/rtl/xcfr_core.sv
// ----------------------------------------------------------------------------
// xcfr_core
// Frame state machine: one input item per step, one result computed per step.
// ----------------------------------------------------------------------------
module xcfr_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [1:0]        func_i,
  input  logic [7:0]        rx_byte_i,
  input  xcfr_pkg::cfg_t    cfg_i,
  output xcfr_pkg::result_t res_o
);
  import xcfr_pkg::*;

  phase_e      phase_q, phase_d;
  logic [15:0] budget_q, budget_d;
  logic [15:0] bytes_q, bytes_d;
  logic [7:0]  xor_q, xor_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  chk_q, chk_d;

  logic        budget_out;
  logic [15:0] budget_dec;
  logic [15:0] bytes_dec;
  logic [15:0] len_full;
  logic        frame_ok;
  result_t     res;

  assign budget_out = (budget_q <= 16'd1);
  assign budget_dec = budget_q - 16'd1;
  assign bytes_dec  = bytes_q - 16'd1;
  assign len_full   = len_q | (cfg_i.len_msb ? {8'h00, rx_byte_i} : {rx_byte_i, 8'h00});
  assign frame_ok   = (chk_q == xor_q) && (rx_byte_i == EndByte) && (cmd_q == cfg_i.exp_cmd);

  always_comb begin
    phase_d  = phase_q;
    budget_d = budget_q;
    bytes_d  = bytes_q;
    xor_d    = xor_q;
    cmd_d    = cmd_q;
    len_d    = len_q;
    chk_d    = chk_q;
    res      = '0;

    if (step_i) begin
      unique case (func_i)
        FuncStart: begin
          phase_d  = PhHunt;
          budget_d = cfg_i.hunt_limit;
          bytes_d  = '0;
          xor_d    = '0;
          cmd_d    = '0;
          len_d    = '0;
          chk_d    = '0;
        end
        FuncTick: begin
          if (phase_q != PhIdle) begin
            if (!budget_out) begin
              budget_d = budget_dec;
            end else begin
              phase_d     = PhIdle;
              budget_d    = '0;
              bytes_d     = '0;
              res.kind    = KindDone;
              res.length  = len_q;
              res.command = cmd_q;
              unique case (phase_q)
                PhHunt:                 res.status = StNoStart;
                PhCmd, PhLen1, PhLen2:  res.status = StHdrTo;
                PhData:                 res.status = StDataTo;
                default:                res.status = StFootTo;
              endcase
            end
          end
        end
        FuncByte: begin
          unique case (phase_q)
            PhIdle: ;
            PhHunt: begin
              if (rx_byte_i == StartByte) begin
                phase_d  = PhCmd;
                budget_d = cfg_i.hdr_to;
              end else if (!budget_out) begin
                budget_d = budget_dec;
              end else begin
                phase_d     = PhIdle;
                budget_d    = '0;
                bytes_d     = '0;
                res.kind    = KindDone;
                res.status  = StNoStart;
                res.length  = len_q;
                res.command = cmd_q;
              end
            end
            PhCmd: begin
              cmd_d   = rx_byte_i;
              xor_d   = xor_q ^ rx_byte_i;
              phase_d = PhLen1;
            end
            PhLen1: begin
              len_d   = cfg_i.len_msb ? {rx_byte_i, 8'h00} : {8'h00, rx_byte_i};
              xor_d   = xor_q ^ rx_byte_i;
              phase_d = PhLen2;
            end
            PhLen2: begin
              len_d = len_full;
              xor_d = xor_q ^ rx_byte_i;
              if (len_full == 16'd0) begin
                phase_d  = PhCheck;
                budget_d = cfg_i.foot_to;
              end else begin
                phase_d  = PhData;
                bytes_d  = len_full;
                budget_d = cfg_i.data_to;
              end
            end
            PhData: begin
              xor_d   = xor_q ^ rx_byte_i;
              bytes_d = bytes_dec;
              if (bytes_dec == 16'd0) begin
                phase_d  = PhCheck;
                budget_d = cfg_i.foot_to;
              end
              res.kind    = KindPayload;
              res.payload = rx_byte_i;
              res.length  = len_q;
              res.command = cmd_q;
            end
            PhCheck: begin
              chk_d   = rx_byte_i;
              phase_d = PhEnd;
            end
            PhEnd: begin
              phase_d     = PhIdle;
              budget_d    = '0;
              bytes_d     = '0;
              res.kind    = KindDone;
              res.status  = frame_ok ? StOk : StBad;
              res.length  = len_q;
              res.command = cmd_q;
            end
            default: ;
          endcase
        end
        default: ;  // unused kind, ignored
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      budget_q <= '0;
      bytes_q  <= '0;
      xor_q    <= '0;
      cmd_q    <= '0;
      len_q    <= '0;
      chk_q    <= '0;
    end else begin
      phase_q  <= phase_d;
      budget_q <= budget_d;
      bytes_q  <= bytes_d;
      xor_q    <= xor_d;
      cmd_q    <= cmd_d;
      len_q    <= len_d;
      chk_q    <= chk_d;
    end
  end

  assign res_o = res;

`ifndef ASSERT_OFF
  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhIdle) |-> (budget_q == 16'd0 && bytes_q == 16'd0))
    else $error("idle phase with live counters");

  a_data_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhData) |-> (bytes_q != 16'd0))
    else $error("payload phase with no bytes left");

  a_payload_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res.kind == KindPayload) |-> (phase_q == PhData))
    else $error("payload result outside payload phase");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && res.kind == KindDone) |=> (phase_q == PhIdle))
    else $error("verdict did not return to idle");
`endif

endmodule

>>> hw/rtl/xcfr_out_reg.sv
// ----------------------------------------------------------------------------
// xcfr_out_reg
// Result register between the frame logic and the output stream.
// ----------------------------------------------------------------------------
module xcfr_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  xcfr_pkg::result_t res_i,
  output logic              can_load_o,
  output logic              valid_o,
  input  logic              ready_i,
  output xcfr_pkg::result_t res_o
);
  import xcfr_pkg::*;

  logic    valid_q, valid_d;
  result_t res_q;

  assign can_load_o = !valid_q || ready_i;
  assign valid_d    = load_i || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

>>> hw/rtl/xor_checked_frame_receiver.sv
// ----------------------------------------------------------------------------
// xor_checked_frame_receiver
// Receiver for STX/ETX framed replies with an XOR checksum and phase timeouts.
// ----------------------------------------------------------------------------
// Every input transfer carries one item (tuser: 0 received byte, 1 millisecond
// tick, 2 start receive) and produces exactly one output transfer, in order.
// A start item begins a hunt for STX (0x02); then come the command byte, two
// length bytes (order set by length_msb_first), the payload, the checksum and
// the end byte. Payload bytes leave as kind 1 results as they arrive; the byte
// in the end position yields a kind 2 verdict: ok when the XOR of command,
// length and payload bytes matches the checksum, the end byte is ETX (0x03)
// and the command equals expected_command, otherwise bad frame. Each phase has
// its own tick budget (the hunt also spends on non-start bytes); running out
// ends the frame with a timeout status. A zero budget acts as one. Items of
// kind 0 results carry all-zero fields. Rate: one item per clock cycle; the
// result of an item is loaded into the result register at the edge of its
// input transfer and is offered on the output in the next cycle. The single
// result register accepts a new item in the same cycle its result is taken,
// so throughput drops only while the output side stalls.
// Configuration writes take effect on the next cycle and must occur while no
// frame is in flight.
// ----------------------------------------------------------------------------
module xor_checked_frame_receiver (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port
  input  logic                          cfg_we_i,
  input  logic [xcfr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [xcfr_pkg::CfgDataW-1:0] cfg_data_i,
  // Input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // [7:0] rx_byte
  input  logic [1:0]                    s_axis_tuser,   // [1:0] func
  // Output stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] payload_byte, [10:8] status, [26:11] frame_length,
  // [34:27] frame_command, [39:35] zero
  output logic [xcfr_pkg::OutDataW-1:0] m_axis_tdata,
  output logic [1:0]                    m_axis_tuser    // [1:0] out_kind
);
  import xcfr_pkg::*;

  cfg_t    cfg;
  result_t core_res;
  result_t out_res;
  logic    can_load;
  logic    step;

  // An item is taken whenever the result register is free or draining.
  assign s_axis_tready = can_load;
  assign step          = s_axis_tvalid && can_load;

  xcfr_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (cfg_we_i),
    .idx_i  (cfg_idx_i),
    .data_i (cfg_data_i),
    .cfg_o  (cfg)
  );

  // Frame state machine; result is combinational from the accepted item.
  xcfr_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .func_i    (s_axis_tuser),
    .rx_byte_i (s_axis_tdata),
    .cfg_i     (cfg),
    .res_o     (core_res)
  );

  // Result register decouples the output stream from the frame logic.
  xcfr_out_reg u_out (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (step),
    .res_i      (core_res),
    .can_load_o (can_load),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .res_o      (out_res)
  );

  assign m_axis_tuser = out_res.kind;
  assign m_axis_tdata = {5'b0_0000, out_res.command, out_res.length,
                         out_res.status, out_res.payload};

endmodule
